### design/mlag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlag_pkg: shared types and constants
// Widths, request and status codes, and the front-to-back command word.
// ----------------------------------------------------------------------------
package mlag_pkg;
  localparam int MAX_LEVELS       = 8;
  localparam int MAX_BASE_ANCHORS = 64;
  localparam int LVL_W  = $clog2(MAX_LEVELS);
  localparam int BASE_W = $clog2(MAX_BASE_ANCHORS);
  localparam int CFG_W  = 21;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_TOTAL = 1'd1;

  typedef enum logic [1:0] {
    REQ_BASE = 2'd0, REQ_LEVEL = 2'd1, REQ_COMPUTE = 2'd2, REQ_NOP = 2'd3
  } req_e;

  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [19:0]       slot;
    logic signed [23:0] base_left;
    logic signed [23:0] base_top;
    logic signed [23:0] base_right;
    logic signed [23:0] base_bottom;
    logic [10:0]       grid_width;
    logic [8:0]        stride_x;
    logic [8:0]        stride_y;
    logic [6:0]        anchors_per_cell;
    logic [5:0]        base_start;
    logic [20:0]       level_end;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        level;
    logic [9:0]        column;
    logic [19:0]       row;
    logic [5:0]        anchor_slot;
    logic signed [23:0] out_left;
    logic signed [23:0] out_top;
    logic signed [23:0] out_right;
    logic signed [23:0] out_bottom;
  } rsp_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic              compute;  // 1: run the divider and shift
    logic [1:0]        status;   // status for non-compute words
    logic [LVL_W-1:0]  lv;
    logic [19:0]       pos;      // offset within the level
  } cmd_t;
endpackage

### design/mlag_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlag_req_if / mlag_rsp_if: valid-ready channels
// Carry request and result words between the block and its neighbours.
// ----------------------------------------------------------------------------
interface mlag_req_if;
  logic valid;
  logic ready;
  mlag_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlag_rsp_if;
  logic valid;
  logic ready;
  mlag_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/mlag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlag_front: request intake and level search
// Writes tables, finds the level of an index and queues a command word.
// ----------------------------------------------------------------------------
module mlag_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  mlag_pkg::req_t        req_i,
  input  logic [3:0]            level_count_i,
  input  logic [20:0]           anchor_total_i,
  input  logic                  back_busy_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output mlag_pkg::cmd_t        cmd_o,
  output logic                  base_we_o,
  output logic [mlag_pkg::BASE_W-1:0] base_addr_o,
  output logic                  lvl_we_o,
  output logic [mlag_pkg::LVL_W-1:0]  lvl_addr_o,
  input  logic [20:0]           end_tab_i [mlag_pkg::MAX_LEVELS]
);
  import mlag_pkg::*;

  // Two-entry queue towards the back end.
  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  logic       is_load;

  cmd_t       cmd_new;
  logic [3:0] nlev;
  logic       found;
  logic [LVL_W-1:0] lv;
  logic [20:0] start;

  // A table load waits until no earlier compute word can still read the tables.
  assign is_load = req_i.req_type inside {REQ_BASE, REQ_LEVEL};
  assign req_ready_o = (cnt_q != 2'd2) && (!is_load || (cnt_q == 2'd0 && !back_busy_i));
  assign push = req_valid_i && req_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_mem_q[rd_ptr_q];

  assign base_we_o   = push && req_i.req_type == REQ_BASE &&
                       {12'd0, req_i.slot} < 32'(MAX_BASE_ANCHORS);
  assign base_addr_o = req_i.slot[BASE_W-1:0];
  assign lvl_we_o    = push && req_i.req_type == REQ_LEVEL &&
                       {12'd0, req_i.slot} < 32'(MAX_LEVELS);
  assign lvl_addr_o  = req_i.slot[LVL_W-1:0];

  always_comb begin
    nlev = level_count_i;
    if (nlev == 4'd0) nlev = 4'd1;
    if (32'(nlev) > MAX_LEVELS) nlev = 4'(MAX_LEVELS);
    found = 1'b0;
    lv = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (i < 32'(nlev) && {1'b0, req_i.slot} < end_tab_i[i]) begin
        found = 1'b1;
        lv = LVL_W'(i);
      end
    end
    start = (lv == '0) ? 21'd0 : end_tab_i[lv - LVL_W'(1)];
    cmd_new.compute = 1'b0;
    cmd_new.status  = ST_WRITTEN;
    cmd_new.lv      = lv;
    cmd_new.pos     = 20'({1'b0, req_i.slot} - start);
    if (req_i.req_type == REQ_COMPUTE) begin
      if ({1'b0, req_i.slot} >= anchor_total_i || !found) begin
        cmd_new.status = ST_RANGE;
      end else begin
        cmd_new.compute = 1'b1;
        cmd_new.status  = ST_VALID;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### design/mlag_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlag_divider: radix-2 restoring divider
// Divides a 20-bit dividend by an 11-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mlag_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [19:0] dividend_i,
  input  logic [10:0] divisor_i,
  output logic        busy_o,
  output logic [19:0] quot_o,
  output logic [10:0] rem_o
);
  logic [4:0]  cnt_q;
  logic [19:0] quot_q;
  logic [11:0] rem_q;
  logic [10:0] div_q;
  logic [11:0] trial;
  logic [12:0] diff;

  assign busy_o = (cnt_q != 5'd0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q[10:0];
  assign trial  = {rem_q[10:0], quot_q[19]};
  assign diff   = {1'b0, trial} - {2'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (start_i) begin
      cnt_q <= 5'd20;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= 12'd0;
      div_q  <= divisor_i;
    end else if (busy_o) begin
      if (!diff[12]) begin
        rem_q  <= diff[11:0];
        quot_q <= {quot_q[18:0], 1'b1};
      end else begin
        rem_q  <= trial;
        quot_q <= {quot_q[18:0], 1'b0};
      end
    end
  end
endmodule

### design/mlag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlag_back: anchor execution
// Splits the offset by two divisions, shifts the base box and saturates.
// ----------------------------------------------------------------------------
module mlag_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  mlag_pkg::cmd_t        cmd_i,
  output logic                  busy_o,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output mlag_pkg::rsp_t        rsp_o,
  output logic [mlag_pkg::LVL_W-1:0]  lvl_rd_o,
  input  logic [10:0]           width_i,
  input  logic [8:0]            stride_x_i,
  input  logic [8:0]            stride_y_i,
  input  logic [6:0]            count_i,
  input  logic [5:0]            bstart_i,
  output logic [mlag_pkg::BASE_W-1:0] base_rd_o,
  input  logic [23:0]           left_i,
  input  logic [23:0]           top_i,
  input  logic [23:0]           right_i,
  input  logic [23:0]           bottom_i
);
  import mlag_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_DIV2, S_MUL, S_BASE, S_ADD, S_OUT
  } state_e;

  state_e      state_q;
  cmd_t        cmd_q;
  logic [19:0] spatial_q, row_q;
  logic [9:0]  col_q;
  logic [5:0]  g_q;
  logic [33:0] sx_q, sy_q;
  logic        div_start, div_busy;
  logic [19:0] div_a, div_quot;
  logic [10:0] div_b, div_rem;
  logic        started_q;
  rsp_t        rsp_q;
  logic        out_full_q;

  function automatic logic [23:0] sat_add(input logic [23:0] b, input logic [33:0] s);
    logic signed [35:0] t;
    t = 36'(signed'(b)) + signed'({2'b0, s});
    if (t > 36'sd8388607) sat_add = 24'h7FFFFF;
    else if (t < -36'sd8388608) sat_add = 24'h800000;
    else sat_add = t[23:0];
  endfunction

  assign lvl_rd_o  = cmd_q.lv;
  assign base_rd_o = g_q;
  assign busy_o    = (state_q != S_IDLE);
  assign cmd_ready_o = (state_q == S_IDLE) && !out_full_q;
  assign rsp_valid_o = out_full_q;
  assign rsp_o = rsp_q;

  always_comb begin
    div_start = 1'b0;
    div_a = cmd_q.pos;
    div_b = {4'd0, (count_i == 7'd0) ? 7'd1 : count_i};
    if (state_q == S_DIV2) begin
      div_a = spatial_q;
      div_b = (width_i == 11'd0) ? 11'd1 : width_i;
    end
    if ((state_q == S_DIV1 || state_q == S_DIV2) && !started_q) div_start = 1'b1;
  end

  mlag_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a),
    .divisor_i(div_b), .busy_o(div_busy), .quot_o(div_quot), .rem_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      started_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) out_full_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            cmd_q <= cmd_i;
            if (cmd_i.compute) begin
              state_q <= S_DIV1;
            end else begin
              rsp_q <= '{status: cmd_i.status, default: '0};
              out_full_q <= 1'b1;
            end
          end
        end
        S_DIV1: begin
          if (started_q && !div_busy) begin
            spatial_q <= div_quot;
            g_q <= 6'(bstart_i + div_rem[5:0]);
            started_q <= 1'b0;
            state_q <= S_DIV2;
          end else begin
            started_q <= 1'b1;
          end
        end
        S_DIV2: begin
          if (started_q && !div_busy) begin
            row_q <= div_quot;
            col_q <= div_rem[9:0];
            started_q <= 1'b0;
            state_q <= S_MUL;
          end else begin
            started_q <= 1'b1;
          end
        end
        S_MUL: begin
          sx_q <= {20'd0, col_q, 4'd0} * 34'(stride_x_i);
          sy_q <= {10'd0, row_q, 4'd0} * 34'(stride_y_i);
          state_q <= S_BASE;
        end
        S_BASE: state_q <= S_ADD;
        S_ADD: begin
          rsp_q.status      <= ST_VALID;
          rsp_q.level       <= 3'(cmd_q.lv);
          rsp_q.column      <= col_q;
          rsp_q.row         <= row_q;
          rsp_q.anchor_slot <= g_q;
          rsp_q.out_left    <= sat_add(left_i, sx_q);
          rsp_q.out_top     <= sat_add(top_i, sy_q);
          rsp_q.out_right   <= sat_add(right_i, sx_q);
          rsp_q.out_bottom  <= sat_add(bottom_i, sy_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_full_q) begin
            out_full_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### design/multi_level_anchor_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_level_anchor_generator: feature pyramid anchor box generator
// Holds base boxes and level tables and maps anchor indices to boxes.
// ----------------------------------------------------------------------------
// A table-load, no-op or out-of-range word passes through the command queue
// and the back end writes its status straight into the result register.
// A compute word passes through the command queue, two passes of the shared
// one-bit-a-cycle divider (start, 20 steps, capture; the offset by anchors
// per cell, then the cell by grid width), a multiply step, a table read
// step, an add/saturate step and a step that presents the word. The back end
// starts its next word only once the result register is empty. The front end
// classifies words and searches the level table in the intake cycle, and a
// two-entry command queue lets it take further compute words while the back
// end is busy. A table-load word is held at the input until the queue and
// the back end are empty, so every compute word sees the tables as they
// stood when it arrived. The result register holds one finished word until
// the consumer takes it. Table contents are undefined until loaded.
module multi_level_anchor_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  mlag_req_if.sink           req_i,
  mlag_rsp_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  logic [mlag_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mlag_pkg::CFG_W-1:0]     cfg_data_i
);
  import mlag_pkg::*;

  logic [3:0]  level_count_q;
  logic [20:0] anchor_total_q;

  // Base box memories and small level tables.
  logic [23:0] left_mem  [MAX_BASE_ANCHORS];
  logic [23:0] top_mem   [MAX_BASE_ANCHORS];
  logic [23:0] right_mem [MAX_BASE_ANCHORS];
  logic [23:0] bot_mem   [MAX_BASE_ANCHORS];
  logic [10:0] width_tab [MAX_LEVELS];
  logic [8:0]  sx_tab    [MAX_LEVELS];
  logic [8:0]  sy_tab    [MAX_LEVELS];
  logic [6:0]  cnt_tab   [MAX_LEVELS];
  logic [5:0]  start_tab [MAX_LEVELS];
  logic [20:0] end_tab   [MAX_LEVELS];

  logic        base_we, lvl_we;
  logic [BASE_W-1:0] base_addr, base_rd;
  logic [LVL_W-1:0]  lvl_addr, lvl_rd;
  logic        cmd_valid, cmd_ready;
  logic        back_busy;
  cmd_t        cmd;
  logic [23:0] left_q, top_q, right_q, bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q  <= 4'd1;
      anchor_total_q <= 21'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEVEL_COUNT:  level_count_q  <= cfg_data_i[3:0];
        CFG_ANCHOR_TOTAL: anchor_total_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      left_mem[base_addr]  <= req_i.data.base_left;
      top_mem[base_addr]   <= req_i.data.base_top;
      right_mem[base_addr] <= req_i.data.base_right;
      bot_mem[base_addr]   <= req_i.data.base_bottom;
    end
    left_q  <= left_mem[base_rd];
    top_q   <= top_mem[base_rd];
    right_q <= right_mem[base_rd];
    bot_q   <= bot_mem[base_rd];
    if (lvl_we) begin
      width_tab[lvl_addr] <= req_i.data.grid_width;
      sx_tab[lvl_addr]    <= req_i.data.stride_x;
      sy_tab[lvl_addr]    <= req_i.data.stride_y;
      cnt_tab[lvl_addr]   <= req_i.data.anchors_per_cell;
      start_tab[lvl_addr] <= req_i.data.base_start;
      end_tab[lvl_addr]   <= req_i.data.level_end;
    end
  end

  mlag_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i(req_i.valid), .req_ready_o(req_i.ready), .req_i(req_i.data),
    .level_count_i(level_count_q), .anchor_total_i(anchor_total_q),
    .back_busy_i(back_busy),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd),
    .base_we_o(base_we), .base_addr_o(base_addr),
    .lvl_we_o(lvl_we), .lvl_addr_o(lvl_addr), .end_tab_i(end_tab)
  );

  mlag_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .busy_o(back_busy),
    .rsp_valid_o(rsp_o.valid), .rsp_ready_i(rsp_o.ready), .rsp_o(rsp_o.data),
    .lvl_rd_o(lvl_rd), .width_i(width_tab[lvl_rd]), .stride_x_i(sx_tab[lvl_rd]),
    .stride_y_i(sy_tab[lvl_rd]), .count_i(cnt_tab[lvl_rd]),
    .bstart_i(start_tab[lvl_rd]), .base_rd_o(base_rd),
    .left_i(left_q), .top_i(top_q), .right_i(right_q), .bottom_i(bot_q)
  );
endmodule

### design/mlag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlag_checker: port-level checks
// Watches result words shown on the top-level ports.
// ----------------------------------------------------------------------------
module mlag_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         rsp_valid,
  input logic         rsp_ready,
  input mlag_pkg::rsp_t rsp
);
  import mlag_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("result dropped");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp.status == ST_WRITTEN || rsp.status == ST_VALID ||
                  rsp.status == ST_RANGE) else $error("bad status");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp.status != ST_VALID |-> rsp.row == '0 && rsp.column == '0)
    else $error("fields not cleared");
endmodule

bind multi_level_anchor_generator mlag_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .rsp_valid(rsp_o.valid),
  .rsp_ready(rsp_o.ready), .rsp(rsp_o.data)
);
